// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define OGRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset only.
`define OGRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/ogru_pkg.sv =====
package ogru_pkg;

    localparam int GRID_DIM_DEF    = 64;
    localparam int MAX_INFLATE_DEF = 7;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_RADIUS = 2'd2;
    localparam logic [6:0] GRID_WIDTH_RST     = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RST    = 7'd64;
    localparam logic [2:0] INFLATE_RADIUS_RST = 3'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // Log-odds cell value and a scratch signed coordinate for clamping.
    typedef logic signed [7:0] t_lo;
    typedef logic signed [9:0] t_sc;

    localparam t_lo LO_MIN    = -8'sd100;
    localparam t_lo LO_MAX    = 8'sd100;
    localparam t_lo OCC_TH    = 8'sd40;
    localparam t_lo OCC_INC   = 8'sd3;
    localparam t_lo FREE_STEP = 8'sd1;

    // Cell operation kinds
    typedef logic [2:0] t_kind;
    localparam t_kind OP_LOWER = 3'd0;
    localparam t_kind OP_RAISE = 3'd1;
    localparam t_kind OP_FLOOR = 3'd2;
    localparam t_kind OP_READ  = 3'd3;
    localparam t_kind OP_CLEAR = 3'd4;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cell_op;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_seq_stat;

endpackage

// ===== sv/ogru_ram.sv =====
module ogru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ogru_rmw.sv =====
module ogru_rmw #(
    parameter int AW = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ogru_pkg::t_cell_op i_op,
    input  logic [AW-1:0]     i_addr,
    output logic [AW-1:0]     o_ram_raddr,
    input  ogru_pkg::t_lo     i_ram_rdata,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output ogru_pkg::t_lo     o_ram_wdata,
    output ogru_pkg::t_lo     o_cur_value
);
    import ogru_pkg::*;

    t_cell_op      r_op;
    logic [AW-1:0] r_addr;
    logic          r_fwd;
    t_lo           r_fwd_data;
    t_lo           cur;
    t_lo           upd;
    logic          we;

    // The read is issued in the same cycle as the previous operation's write,
    // so a match on that address takes the value being written instead.
    assign o_ram_raddr = i_addr;
    assign cur         = r_fwd ? r_fwd_data : i_ram_rdata;

    always_comb begin
        upd = cur;
        case (r_op.kind)
            OP_LOWER: upd = (cur <= LO_MIN) ? LO_MIN : cur - FREE_STEP;
            OP_RAISE: upd = (cur > LO_MAX - OCC_INC) ? LO_MAX : cur + OCC_INC;
            OP_FLOOR: upd = (cur < OCC_TH) ? OCC_TH : cur;
            OP_CLEAR: upd = '0;
            default:  upd = cur;
        endcase
    end

    assign we          = r_op.valid && (r_op.kind != OP_READ);
    assign o_ram_we    = we;
    assign o_ram_waddr = r_addr;
    assign o_ram_wdata = upd;
    assign o_cur_value = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_op  <= i_op;
            r_fwd <= i_op.valid && we && (i_addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= i_addr;
        r_fwd_data <= upd;
    end

endmodule

// ===== sv/ogru_seq.sv =====
module ogru_seq #(
    parameter int GRID_DIM    = ogru_pkg::GRID_DIM_DEF,
    parameter int MAX_INFLATE = ogru_pkg::MAX_INFLATE_DEF,
    parameter int AW          = $clog2(GRID_DIM * GRID_DIM)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [5:0]         i_start_x,
    input  logic [5:0]         i_start_y,
    input  ogru_pkg::t_lo      i_end_x,
    input  ogru_pkg::t_lo      i_end_y,
    input  logic               i_hit,
    input  logic [6:0]         i_grid_width,
    input  logic [6:0]         i_grid_height,
    input  logic [2:0]         i_inflate_radius,
    output ogru_pkg::t_cell_op o_op,
    output logic [AW-1:0]      o_addr,
    input  ogru_pkg::t_lo      i_cur_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ogru_pkg::t_lo      o_cell_value,
    output logic               o_status,
    output ogru_pkg::t_seq_stat o_stat
);
    import ogru_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int CW    = $clog2(GRID_DIM);
    localparam int WW    = $clog2(GRID_DIM + 1);
    localparam int RW    = (MAX_INFLATE < 2) ? 1 : $clog2(MAX_INFLATE + 1);
    localparam int EW    = CW + 2;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_READ   = 4'd2;
    localparam logic [3:0] ST_RDWAIT = 4'd3;
    localparam logic [3:0] ST_SETUP  = 4'd4;
    localparam logic [3:0] ST_WALK   = 4'd5;
    localparam logic [3:0] ST_END    = 4'd6;
    localparam logic [3:0] ST_DISK   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;

    logic [CW-1:0]        r_x, n_x, r_y, n_y;
    logic [CW-1:0]        r_x1, n_x1, r_y1, n_y1;
    logic [CW-1:0]        r_min_y, n_min_y, r_max_x, n_max_x, r_max_y, n_max_y;
    logic signed [EW-1:0] r_dx, n_dx, r_dy, n_dy, r_err, n_err;
    logic                 r_sx, n_sx, r_sy, n_sy;
    logic                 r_hit, n_hit;
    t_lo                  r_res_value, n_res_value;
    logic                 r_res_status, n_res_status;
    t_lo                  r_out_value, n_out_value;
    logic                 r_out_status, n_out_status;

    logic [WW-1:0]        w_cap, h_cap;
    logic [RW-1:0]        rad;
    t_sc                  w_sc, h_sc, wm1, hm1;
    t_sc                  sx_sc, sy_sc, ex_sc, ey_sc, ex_cl, ey_cl;
    logic                 outside;
    logic signed [EW-1:0] ddx, ddy, adx, ady;
    logic signed [EW:0]   e2;
    logic                 at_end, step_x, step_y;
    t_sc                  lo_x, hi_x, lo_y, hi_y;
    t_sc                  ox, oy, ax, ay;
    logic [RW-1:0]        axr, ayr;
    logic [2*RW-1:0]      sq_x, sq_y, sq_r;
    logic [2*RW:0]        d2;
    logic                 in_disk;
    logic [AW-1:0]        cell_addr;
    logic                 load_out;

    // Grid size and radius, saturated to the GRID_DIM and MAX_INFLATE parameters.
    assign w_cap = (int'(i_grid_width) > GRID_DIM) ? WW'(GRID_DIM) : WW'(i_grid_width);
    assign h_cap = (int'(i_grid_height) > GRID_DIM) ? WW'(GRID_DIM) : WW'(i_grid_height);
    assign rad   = (int'(i_inflate_radius) > MAX_INFLATE) ? RW'(MAX_INFLATE)
                                                           : RW'(i_inflate_radius);
    assign w_sc  = t_sc'(w_cap);
    assign h_sc  = t_sc'(h_cap);
    assign wm1   = w_sc - t_sc'(1);
    assign hm1   = h_sc - t_sc'(1);

    // Input decode
    assign sx_sc   = t_sc'(i_start_x);
    assign sy_sc   = t_sc'(i_start_y);
    assign ex_sc   = t_sc'(i_end_x);
    assign ey_sc   = t_sc'(i_end_y);
    assign outside = (sx_sc >= w_sc) || (sy_sc >= h_sc);
    assign ex_cl   = (ex_sc < 0) ? '0 : ((ex_sc > wm1) ? wm1 : ex_sc);
    assign ey_cl   = (ey_sc < 0) ? '0 : ((ey_sc > hm1) ? hm1 : ey_sc);

    // Line setup
    assign ddx = $signed({2'b00, r_x1}) - $signed({2'b00, r_x});
    assign ddy = $signed({2'b00, r_y1}) - $signed({2'b00, r_y});
    assign adx = (ddx < 0) ? -ddx : ddx;
    assign ady = (ddy < 0) ? -ddy : ddy;

    // Line step
    assign e2     = {r_err, 1'b0};
    assign at_end = (r_x == r_x1) && (r_y == r_y1);
    assign step_x = (e2 >= r_dy);
    assign step_y = (e2 <= r_dx);

    // Disk window bounds around the end cell
    assign lo_x = t_sc'(r_x) - t_sc'(rad);
    assign hi_x = t_sc'(r_x) + t_sc'(rad);
    assign lo_y = t_sc'(r_y) - t_sc'(rad);
    assign hi_y = t_sc'(r_y) + t_sc'(rad);

    // Disk membership of the current scan cell
    assign ox      = t_sc'(r_x) - t_sc'(r_x1);
    assign oy      = t_sc'(r_y) - t_sc'(r_y1);
    assign ax      = (ox < 0) ? -ox : ox;
    assign ay      = (oy < 0) ? -oy : oy;
    assign axr     = ax[RW-1:0];
    assign ayr     = ay[RW-1:0];
    assign sq_x    = axr * axr;
    assign sq_y    = ayr * ayr;
    assign sq_r    = rad * rad;
    assign d2      = {1'b0, sq_x} + {1'b0, sq_y};
    assign in_disk = (d2 <= {1'b0, sq_r});

    assign cell_addr = AW'(r_y) * AW'(GRID_DIM) + AW'(r_x);
    assign o_addr    = (r_state == ST_CLEAR) ? r_clr : cell_addr;

    always_comb begin
        o_op = '0;
        case (r_state)
            ST_CLEAR: o_op = '{valid: 1'b1, kind: OP_CLEAR};
            ST_READ:  o_op = '{valid: 1'b1, kind: OP_READ};
            ST_WALK:  o_op = '{valid: !at_end, kind: OP_LOWER};
            ST_END:   o_op = '{valid: 1'b1, kind: OP_RAISE};
            ST_DISK:  o_op = '{valid: in_disk, kind: OP_FLOOR};
            default:  o_op = '0;
        endcase
    end

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_x          = r_x;
        n_y          = r_y;
        n_x1         = r_x1;
        n_y1         = r_y1;
        n_min_y      = r_min_y;
        n_max_x      = r_max_x;
        n_max_y      = r_max_y;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_err        = r_err;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_hit        = r_hit;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x          = CW'(i_start_x);
                    n_y          = CW'(i_start_y);
                    n_x1         = ex_cl[CW-1:0];
                    n_y1         = ey_cl[CW-1:0];
                    n_hit        = i_hit;
                    n_res_value  = '0;
                    n_res_status = outside;
                    if (outside) begin
                        n_state = ST_DONE;
                    end else if (i_operation) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                n_res_value = i_cur_value;
                n_state     = ST_DONE;
            end
            ST_SETUP: begin
                n_dx    = adx;
                n_dy    = -ady;
                n_err   = adx - ady;
                n_sx    = (r_x < r_x1);
                n_sy    = (r_y < r_y1);
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (at_end) begin
                    n_state = r_hit ? ST_END : ST_DONE;
                end else begin
                    n_err = r_err + (step_x ? r_dy : '0) + (step_y ? r_dx : '0);
                    if (step_x) begin
                        n_x = r_sx ? r_x + CW'(1) : r_x - CW'(1);
                    end
                    if (step_y) begin
                        n_y = r_sy ? r_y + CW'(1) : r_y - CW'(1);
                    end
                end
            end
            ST_END: begin
                n_x     = (lo_x < 0) ? '0 : lo_x[CW-1:0];
                n_y     = (lo_y < 0) ? '0 : lo_y[CW-1:0];
                n_min_y = (lo_y < 0) ? '0 : lo_y[CW-1:0];
                n_max_x = (hi_x > wm1) ? wm1[CW-1:0] : hi_x[CW-1:0];
                n_max_y = (hi_y > hm1) ? hm1[CW-1:0] : hi_y[CW-1:0];
                n_state = ST_DISK;
            end
            ST_DISK: begin
                if (r_y == r_max_y) begin
                    if (r_x == r_max_x) begin
                        n_state = ST_DONE;
                    end else begin
                        n_x = r_x + CW'(1);
                        n_y = r_min_y;
                    end
                end else begin
                    n_y = r_y + CW'(1);
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_res_value;
            n_out_status = r_res_status;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_y          <= n_y;
        r_x1         <= n_x1;
        r_y1         <= n_y1;
        r_min_y      <= n_min_y;
        r_max_x      <= n_max_x;
        r_max_y      <= n_max_y;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_err        <= n_err;
        r_sx         <= n_sx;
        r_sy         <= n_sy;
        r_hit        <= n_hit;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cell_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_stat        = '{clearing: (r_state == ST_CLEAR), idle: (r_state == ST_IDLE)};

endmodule

// ===== sv/occupancy_grid_ray_update.sv =====
// Channel  Dir  Handshake                       Word contents (low bit first)
// s_axis   in   s_axis_tvalid / s_axis_tready   tdata: start_x, start_y, end_x, end_y, hit
//                                               tuser: operation
// m_axis   out  m_axis_tvalid / m_axis_tready   tdata: cell_value; tuser: status
// cfg      in   i_cfg_we, no wait state         i_cfg_index, i_cfg_data
//
// One word is processed at a time, one grid cell per cycle through a single
// read-modify-write pass over the cell memory (read port, then write port).
// A read word reads its one cell; an out-of-grid word goes straight to its
// result. A ray word walks the line from start to end cell, and on a hit then
// scans the window of up to (2r+1)^2 cells around the end cell.
// After reset the memory is cleared, one cell per cycle; no word is accepted
// meanwhile, though configuration writes are taken. A result waiting on
// m_axis does not stop the next word from being accepted and worked on.
`include "assert_macros.svh"

module occupancy_grid_ray_update #(
    parameter int GRID_DIM    = ogru_pkg::GRID_DIM_DEF,
    parameter int MAX_INFLATE = ogru_pkg::MAX_INFLATE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Ray or read request word.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] start_x, [11:6] start_y, [19:12] end_x, [27:20] end_y, [28] hit
    input  logic [ogru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]                       s_axis_tuser,
    // Result word.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] cell_value
    output logic [ogru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] status
    output logic [0:0]                       m_axis_tuser,
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ogru_pkg::CFG_W-1:0]       i_cfg_data
);
    import ogru_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [6:0]    r_grid_width;
    logic [6:0]    r_grid_height;
    logic [2:0]    r_inflate_radius;

    t_lo           end_x, end_y;
    t_cell_op      cell_op;
    logic [AW-1:0] cell_addr;
    t_lo           cur_value;
    t_lo           out_value;
    logic          out_status;
    t_seq_stat     seq_stat;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic          ram_we;
    t_lo           ram_wdata;
    logic [7:0]    ram_rdata;

    // The user must change registers only between words (not enforced here); the sequencer uses them live.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= GRID_WIDTH_RST;
            r_grid_height    <= GRID_HEIGHT_RST;
            r_inflate_radius <= INFLATE_RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:     r_grid_width     <= i_cfg_data;
                CFG_GRID_HEIGHT:    r_grid_height    <= i_cfg_data;
                CFG_INFLATE_RADIUS: r_inflate_radius <= i_cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    assign end_x = s_axis_tdata[19:12];
    assign end_y = s_axis_tdata[27:20];

    // Sequencer: clearing sweep, decode, cell read, line walk, inflation window scan and result register.
    ogru_seq #(
        .GRID_DIM    (GRID_DIM),
        .MAX_INFLATE (MAX_INFLATE),
        .AW          (AW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_operation      (s_axis_tuser[0]),
        .i_start_x        (s_axis_tdata[5:0]),
        .i_start_y        (s_axis_tdata[11:6]),
        .i_end_x          (end_x),
        .i_end_y          (end_y),
        .i_hit            (s_axis_tdata[28]),
        .i_grid_width     (r_grid_width),
        .i_grid_height    (r_grid_height),
        .i_inflate_radius (r_inflate_radius),
        .o_op             (cell_op),
        .o_addr           (cell_addr),
        .i_cur_value      (cur_value),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_cell_value     (out_value),
        .o_status         (out_status),
        .o_stat           (seq_stat)
    );

    assign m_axis_tdata = out_value;
    assign m_axis_tuser = out_status;

    // Cell update stage with write-to-read forwarding.
    ogru_rmw #(
        .AW (AW)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (cell_op),
        .i_addr      (cell_addr),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_cur_value (cur_value)
    );

    // Log-odds cell store, cell (x, y) at entry y * GRID_DIM + x.
    ogru_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One word at a time: the input closes right after an accept.
    `OGRU_ASSERT_NXT(a_one_word, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // No word is taken while the clearing sweep runs.
    `OGRU_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, seq_stat.clearing, !s_axis_tready)
    // Every stored value stays inside the saturation limits.
    `OGRU_ASSERT_IMP(a_wdata_range, i_clk, i_rst_n, ram_we, (ram_wdata >= LO_MIN) && (ram_wdata <= LO_MAX))
    // The update pipeline is drained whenever the block waits for a word, except
    // in the first idle cycle, which still retires the last clearing write.
    `OGRU_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, seq_stat.idle && !$past(seq_stat.clearing), !ram_we)

endmodule
